[hdl/assert_macros.svh]
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define SGF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked assertion that is also checked during reset.
`define SGF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hdl/sgf_pkg.sv]
// Shared constants, types and arithmetic helpers of the 5x5 Gaussian filter.
package sgf_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int PIX_W      = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int FW_W       = COL_W + 1;
  localparam int CFG_W_W    = 9;
  localparam int CFG_H_W    = 16;
  localparam int ROW_W      = CFG_H_W + 1;
  localparam int SUM_W      = PIX_W + 4;
  localparam int NSLOTS     = 4;
  localparam int SLOT_W     = $clog2(NSLOTS);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [NSLOTS-1:0] row_word_t;

  typedef struct packed {
    logic             re;
    logic [COL_W-1:0] addr;
  } row_rd_t;

  typedef struct packed {
    logic             we;
    logic [COL_W-1:0] addr;
    row_word_t        data;
  } row_wr_t;

  // 1-4-6-4-1 weighted sum
  function automatic logic [SUM_W-1:0] tap_sum(pix_t a, pix_t b, pix_t c, pix_t d, pix_t e);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + (SUM_W'(b) << 2) + (SUM_W'(c) << 2) + (SUM_W'(c) << 1)
      + (SUM_W'(d) << 2) + SUM_W'(e);
    return s;
  endfunction

  // (sum + 8) >> 4, kept to pixel width
  function automatic pix_t round16(logic [SUM_W-1:0] s);
    logic [SUM_W:0] t;
    t = {1'b0, s} + (SUM_W + 1)'(8);
    return t[PIX_W+3:4];
  endfunction

endpackage

[hdl/sgf_row_mem.sv]
// Line store: one word per column holding the horizontal results of four rows.
module sgf_row_mem (
  input  logic                clk_i,
  input  sgf_pkg::row_rd_t    rd_i,
  input  sgf_pkg::row_wr_t    wr_i,
  output sgf_pkg::row_word_t  rd_data_o
);

  sgf_pkg::row_word_t mem [sgf_pkg::MAX_WIDTH];
  sgf_pkg::row_word_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.re) begin
      rd_data_q <= mem[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hdl/separable_gaussian_5x5_filter_unit.sv]
// Separable 5x5 Gaussian blur over a raster pixel stream.
// Throughput: one transaction per clock when not stalled; pixel-phase flushes are dropped.
// Pipeline: an accepted transaction moves through the stage-1 register to the output register;
//   the result of a pixel rides on the transaction 2*width+2 places later in the stream.
// The per-column line store word is read at acceptance and written back one stage later.
// Reset clears position, window, frame size and handshake state; the line store is not cleared.
module separable_gaussian_5x5_filter_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              command_i,
  input  logic [sgf_pkg::PIX_W-1:0]         pixel_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sgf_pkg::PIX_W-1:0]         filtered_o,
  output logic                              frame_end_o,
  input  logic                              cfg_we_i,
  input  logic [sgf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sgf_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  typedef struct packed {
    logic                        use_fresh;
    logic [sgf_pkg::SLOT_W-1:0]  slot;
  } vtap_t;

  // configuration and latched frame size
  logic [sgf_pkg::CFG_W_W-1:0] width_q;
  logic [sgf_pkg::CFG_H_W-1:0] height_q;
  logic [sgf_pkg::FW_W-1:0]    frame_w_q, frame_w_d;
  logic [sgf_pkg::CFG_H_W-1:0] frame_h_q, frame_h_d;

  // position and window
  logic [sgf_pkg::COL_W-1:0]   c_q, c_d;
  logic [sgf_pkg::ROW_W-1:0]   r_q, r_d;
  sgf_pkg::pix_t               win_q [5];
  sgf_pkg::pix_t               win_n [5];

  // stage 1
  logic                        s1_valid_q;
  logic                        s1_res_q;
  logic                        s1_wr_q;
  logic                        s1_last_q;
  logic [sgf_pkg::COL_W-1:0]   s1_col_q;
  logic [sgf_pkg::SLOT_W-1:0]  s1_lo_q;
  sgf_pkg::pix_t               s1_fresh_q;
  vtap_t                       s1_tap_q [5];

  // output register
  logic                        out_valid_q;
  sgf_pkg::pix_t               filtered_q;
  logic                        frame_end_q;

  logic                        pixel_phase, ignore, accept, take, frame_start;
  sgf_pkg::pix_t               pix_eff;
  logic                        have_pos, fresh_ok, has_res, is_last;
  logic [sgf_pkg::ROW_W-1:0]   crow;
  logic [sgf_pkg::COL_W-1:0]   ccol;
  logic [sgf_pkg::ROW_W-1:0]   h_ext;
  logic                        first_col, second_col, last_col, second_last_col;
  logic [2:0]                  hp [5];
  sgf_pkg::pix_t               fresh;
  logic [sgf_pkg::SLOT_W-1:0]  lo;
  vtap_t                       tap_n [5];
  logic                        s1_adv;
  sgf_pkg::pix_t               vval [5];
  sgf_pkg::pix_t               vres;
  sgf_pkg::row_rd_t            rd_req;
  sgf_pkg::row_wr_t            wr_req;
  sgf_pkg::row_word_t          rd_data;
  sgf_pkg::row_word_t          wr_word;

  sgf_row_mem u_row_mem (
    .clk_i     (clk_i),
    .rd_i      (rd_req),
    .wr_i      (wr_req),
    .rd_data_o (rd_data)
  );

  // ---------------- stage 0: decode the incoming transaction ----------------
  assign h_ext       = sgf_pkg::ROW_W'(frame_h_q);
  assign pixel_phase = r_q < h_ext;
  assign ignore      = pixel_phase && (command_i == sgf_pkg::CMD_FLUSH);
  assign accept      = in_valid_i && in_ready_o;
  assign take        = accept && !ignore;
  assign frame_start = (r_q == '0) && (c_q == '0);
  assign pix_eff     = pixel_phase ? pixel_i : '0;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      win_n[i] = win_q[i+1];
    end
    win_n[4] = pix_eff;
  end

  // column and row whose horizontal result this transaction completes
  always_comb begin
    have_pos = 1'b0;
    crow     = r_q;
    ccol     = '0;
    if (c_q >= sgf_pkg::COL_W'(2)) begin
      have_pos = 1'b1;
      ccol     = c_q - sgf_pkg::COL_W'(2);
    end else if (r_q != '0) begin
      have_pos = 1'b1;
      crow     = r_q - sgf_pkg::ROW_W'(1);
      ccol     = sgf_pkg::COL_W'(frame_w_q - sgf_pkg::FW_W'(2) + sgf_pkg::FW_W'(c_q));
    end
  end

  assign fresh_ok = have_pos && (crow < h_ext);
  assign has_res  = have_pos && (crow >= sgf_pkg::ROW_W'(2));

  assign first_col       = ccol == '0;
  assign second_col      = ccol == sgf_pkg::COL_W'(1);
  assign last_col        = sgf_pkg::FW_W'(ccol) == frame_w_q - sgf_pkg::FW_W'(1);
  assign second_last_col = sgf_pkg::FW_W'(ccol) == frame_w_q - sgf_pkg::FW_W'(2);

  assign is_last = has_res && last_col && (crow == h_ext + sgf_pkg::ROW_W'(1));

  // mirrored window positions at the left and right edges
  always_comb begin
    hp[0] = first_col ? 3'd4 : (second_col ? 3'd2 : 3'd0);
    hp[1] = first_col ? 3'd3 : 3'd1;
    hp[2] = 3'd2;
    hp[3] = last_col ? 3'd1 : 3'd3;
    hp[4] = last_col ? 3'd0 : (second_last_col ? 3'd2 : 3'd4);
  end

  assign fresh = sgf_pkg::round16(sgf_pkg::tap_sum(win_n[hp[0]], win_n[hp[1]], win_n[hp[2]],
                                                   win_n[hp[3]], win_n[hp[4]]));

  // vertical taps: slot of row crow-k is lo-k; the current row comes from fresh
  assign lo = crow[sgf_pkg::SLOT_W-1:0];

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      tap_n[i] = '0;
    end
    // top edge
    if (crow == sgf_pkg::ROW_W'(2)) begin
      tap_n[0].use_fresh = 1'b1;
    end else if (crow == sgf_pkg::ROW_W'(3)) begin
      tap_n[0].slot = lo - sgf_pkg::SLOT_W'(2);
    end else begin
      tap_n[0].slot = lo;
    end
    tap_n[1].slot = (crow == sgf_pkg::ROW_W'(2)) ? lo - sgf_pkg::SLOT_W'(1)
                                                 : lo - sgf_pkg::SLOT_W'(3);
    tap_n[2].slot = lo - sgf_pkg::SLOT_W'(2);
    // bottom edge
    tap_n[3].slot = (crow == h_ext + sgf_pkg::ROW_W'(1)) ? lo - sgf_pkg::SLOT_W'(3)
                                                         : lo - sgf_pkg::SLOT_W'(1);
    if (crow == h_ext + sgf_pkg::ROW_W'(1)) begin
      tap_n[4].slot = lo;
    end else if (crow == h_ext) begin
      tap_n[4].slot = lo - sgf_pkg::SLOT_W'(2);
    end else begin
      tap_n[4].use_fresh = 1'b1;
    end
  end

  assign rd_req.re   = take;
  assign rd_req.addr = ccol;

  // next position
  always_comb begin
    c_d = c_q;
    r_d = r_q;
    if (take) begin
      if (is_last) begin
        c_d = '0;
        r_d = '0;
      end else if (sgf_pkg::FW_W'(c_q) + sgf_pkg::FW_W'(1) >= frame_w_q) begin
        c_d = '0;
        r_d = r_q + sgf_pkg::ROW_W'(1);
      end else begin
        c_d = c_q + sgf_pkg::COL_W'(1);
      end
    end
  end

  // latch the clamped frame size on the first pixel of a frame
  always_comb begin
    frame_w_d = frame_w_q;
    frame_h_d = frame_h_q;
    if (take && frame_start) begin
      if (int'(width_q) < 3) begin
        frame_w_d = sgf_pkg::FW_W'(3);
      end else if (int'(width_q) > sgf_pkg::MAX_WIDTH) begin
        frame_w_d = sgf_pkg::FW_W'(sgf_pkg::MAX_WIDTH);
      end else begin
        frame_w_d = sgf_pkg::FW_W'(width_q);
      end
      frame_h_d = (height_q < sgf_pkg::CFG_H_W'(3)) ? sgf_pkg::CFG_H_W'(3) : height_q;
    end
  end

  // ---------------- stage 1: vertical pass and write-back ----------------
  assign s1_adv     = s1_valid_q && (!s1_res_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      vval[i] = s1_tap_q[i].use_fresh ? s1_fresh_q : rd_data[s1_tap_q[i].slot];
    end
  end

  assign vres = sgf_pkg::round16(sgf_pkg::tap_sum(vval[0], vval[1], vval[2], vval[3], vval[4]));

  always_comb begin
    wr_word          = rd_data;
    wr_word[s1_lo_q] = s1_fresh_q;
  end

  assign wr_req.we   = s1_adv && s1_wr_q;
  assign wr_req.addr = s1_col_q;
  assign wr_req.data = wr_word;

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= sgf_pkg::CFG_W_W'(256);
      height_q  <= sgf_pkg::CFG_H_W'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sgf_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[sgf_pkg::CFG_W_W-1:0];
        sgf_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i[sgf_pkg::CFG_H_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_w_q <= sgf_pkg::FW_W'(sgf_pkg::MAX_WIDTH);
      frame_h_q <= sgf_pkg::CFG_H_W'(256);
      c_q       <= '0;
      r_q       <= '0;
      for (int i = 0; i < 5; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      frame_w_q <= frame_w_d;
      frame_h_q <= frame_h_d;
      c_q       <= c_d;
      r_q       <= r_d;
      if (take) begin
        for (int i = 0; i < 5; i++) begin
          win_q[i] <= win_n[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_res_q   <= has_res;
      s1_wr_q    <= fresh_ok;
      s1_last_q  <= is_last;
      s1_col_q   <= ccol;
      s1_lo_q    <= lo;
      s1_fresh_q <= fresh;
      for (int i = 0; i < 5; i++) begin
        s1_tap_q[i] <= tap_n[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_res_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_res_q) begin
      filtered_q  <= vres;
      frame_end_q <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;
  assign frame_end_o = frame_end_q;

endmodule

[hdl/sgf_checker.sv]
// Port-level checker for the Gaussian filter, bound to the top level.
`include "assert_macros.svh"

module sgf_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [sgf_pkg::PIX_W-1:0]  filtered_o,
  input logic                       frame_end_o
);

  // hold the result while the sink stalls
  `SGF_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(filtered_o) && $stable(frame_end_o), "output changed while stalled")

  `SGF_ASSERT_RST(a_rst_idle, !rst_ni |-> !out_valid_o, "result shown during reset")

  // the first items of a frame give no result
  `SGF_ASSERT(a_frame_gap, out_valid_o && out_ready_i && frame_end_o |=> !out_valid_o, "result right after end of frame")

  // a new result needs an input transaction that passed through the stage-1 register
  `SGF_ASSERT(a_res_origin, $rose(out_valid_o) |-> ($past(in_valid_i && in_ready_o, 2)), "result without input transaction")

endmodule

bind separable_gaussian_5x5_filter_unit sgf_checker u_sgf_checker (.*);
